/* sv/vector_angle_atan_approx_assert.svh */
`ifndef VECTOR_ANGLE_ATAN_APPROX_ASSERT_SVH
`define VECTOR_ANGLE_ATAN_APPROX_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define VAA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/vaa_pkg.sv */
package vaa_pkg;

    localparam int unsigned IN_W   = 16;  // d and q fields
    localparam int unsigned DM_W   = 16;  // |d|, up to 32768
    localparam int unsigned QM_W   = 15;  // q, 1..32767
    localparam int unsigned PDQ_W  = 30;  // |d|*q
    localparam int unsigned QQ_W   = 30;  // q*q
    localparam int unsigned DD_W   = 31;  // d*d, up to 2^30
    localparam int unsigned NUM_W  = 60;
    localparam int unsigned DEN_W  = 41;
    localparam int unsigned QUO_W  = 20;  // quotient never reaches 2^20
    localparam int unsigned OUT_W  = 31;
    localparam int unsigned OUT_SH = 10;  // times 1024
    localparam int unsigned QW_SH  = 10;  // q*q weight 1024

    localparam logic [29:0] ATAN_SCALE = 30'd683565275;
    localparam logic [8:0]  D_WEIGHT   = 9'd287;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_tag;

endpackage

/* sv/vaa_front.sv */
module vaa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vaa_pkg::IN_W-1:0]    i_d,
    input  logic [vaa_pkg::IN_W-1:0]    i_q,
    output vaa_pkg::t_tag               o_tag,
    input  logic                        i_ready,
    output logic [vaa_pkg::NUM_W-1:0]   o_num,
    output logic [vaa_pkg::DEN_W-1:0]   o_den
);
    import vaa_pkg::*;

    // stage A: magnitudes
    t_tag              r_a_tag, n_a_tag;
    logic [DM_W-1:0]   r_dm, n_dm;
    logic [QM_W-1:0]   r_qm, n_qm;
    // stage B: products
    t_tag              r_b_tag;
    logic [PDQ_W-1:0]  r_pdq, n_pdq;
    logic [QQ_W-1:0]   r_qq, n_qq;
    logic [DD_W-1:0]   r_dd, n_dd;
    // stage C: numerator and denominator
    t_tag              r_c_tag;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_den, n_den;

    logic              w_en_a, w_en_b, w_en_c, w_zero;
    logic [31:0]       w_pdq, w_qq, w_dd;

    assign w_en_c  = !r_c_tag.valid || i_ready;
    assign w_en_b  = !r_b_tag.valid || w_en_c;
    assign w_en_a  = !r_a_tag.valid || w_en_b;
    assign o_ready = w_en_a;

    // q <= 0: feed |d| = 0, q = 1 so the quotient comes out zero
    assign w_zero = i_q[IN_W-1] || (i_q == '0);

    always_comb begin
        n_a_tag.valid = i_valid;
        n_a_tag.neg   = i_d[IN_W-1] && !w_zero;
        n_dm = w_zero ? '0 : (i_d[IN_W-1] ? DM_W'(-i_d) : i_d);
        n_qm = w_zero ? QM_W'(1) : i_q[QM_W-1:0];
    end

    assign w_pdq = 32'(r_dm) * 32'(r_qm);
    assign w_qq  = 32'(r_qm) * 32'(r_qm);
    assign w_dd  = 32'(r_dm) * 32'(r_dm);

    always_comb begin
        n_pdq = w_pdq[PDQ_W-1:0];
        n_qq  = w_qq[QQ_W-1:0];
        n_dd  = w_dd[DD_W-1:0];
        n_num = NUM_W'(r_pdq) * NUM_W'(ATAN_SCALE);
        n_den = (DEN_W'(r_qq) << QW_SH) + DEN_W'(r_dd) * DEN_W'(D_WEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
        end else begin
            if (w_en_a) r_a_tag <= n_a_tag;
            if (w_en_b) r_b_tag <= r_a_tag;
            if (w_en_c) r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_dm <= n_dm;
            r_qm <= n_qm;
        end
        if (w_en_b) begin
            r_pdq <= n_pdq;
            r_qq  <= n_qq;
            r_dd  <= n_dd;
        end
        if (w_en_c) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    assign o_tag = r_c_tag;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

/* sv/vaa_div_step.sv */
`include "vector_angle_atan_approx_assert.svh"

module vaa_div_step #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vaa_pkg::t_tag               i_tag,
    output logic                        o_ready,
    input  logic [vaa_pkg::NUM_W-1:0]   i_rem,
    input  logic [vaa_pkg::DEN_W-1:0]   i_den,
    input  logic [vaa_pkg::QUO_W-1:0]   i_quo,
    output vaa_pkg::t_tag               o_tag,
    input  logic                        i_ready,
    output logic [vaa_pkg::NUM_W-1:0]   o_rem,
    output logic [vaa_pkg::DEN_W-1:0]   o_den,
    output logic [vaa_pkg::QUO_W-1:0]   o_quo
);
    import vaa_pkg::*;

    t_tag              r_tag;
    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [NUM_W-1:0]  w_dsh;
    logic              w_en, w_fit;

    assign w_en    = !r_tag.valid || i_ready;
    assign o_ready = w_en;

    // one restoring step: quotient bit SHIFT
    assign w_dsh = NUM_W'(i_den) << SHIFT;
    assign w_fit = (i_rem >= w_dsh);

    always_comb begin
        n_rem        = w_fit ? (i_rem - w_dsh) : i_rem;
        n_quo        = i_quo;
        n_quo[SHIFT] = w_fit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (w_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

    // partial remainder stays below the shifted divisor
    `VAA_ASSERT_NOW(a_rem_bound, r_tag.valid, r_rem < (NUM_W'(r_den) << SHIFT))
    // stalled item keeps its place and its remainder
    `VAA_ASSERT_NEXT(a_stall_hold, r_tag.valid && !i_ready, r_tag.valid && $stable(r_rem))
    // an item taken from upstream shows up here next cycle
    `VAA_ASSERT_NEXT(a_take, i_tag.valid && o_ready, r_tag.valid)

endmodule

/* sv/vector_angle_atan_approx.sv */
// Pipeline: 3 front stages, 20 divider stages, 1 output stage.
// Throughput: one item per cycle while m_axis_tready is high; bubbles are
//   squeezed out under back-pressure.
// Reset: synchronous, active low, clears all stage valid bits; data regs are not reset.
module vector_angle_atan_approx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] d_component, [31:16] q_component
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [30:0] phase_angle, [31] zero
);
    import vaa_pkg::*;

    // Pipeline chain. Index 0 is the front end output, index QUO_W the last
    // divider stage. Every stage loads when it is empty or its successor loads,
    // so ready ripples back combinationally and holes fill up while stalled.
    t_tag             w_tag [0:QUO_W];
    logic             w_rdy [0:QUO_W];
    logic [NUM_W-1:0] w_rem [0:QUO_W];
    logic [DEN_W-1:0] w_den [0:QUO_W];
    logic [QUO_W-1:0] w_quo [0:QUO_W];

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;
    logic [OUT_W-1:0] w_mag;
    logic             w_en_out;

    // Front end: |d|, q, products, then numerator |d|*q*683565275 and
    // denominator 1024*q*q + 287*d*d. q <= 0 is mapped to a zero numerator.
    vaa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_d     (s_axis_tdata[15:0]),
        .i_q     (s_axis_tdata[31:16]),
        .o_tag   (w_tag[0]),
        .i_ready (w_rdy[0]),
        .o_num   (w_rem[0]),
        .o_den   (w_den[0])
    );

    assign w_quo[0] = '0;

    // Restoring divider, one quotient bit per stage, MSB first. The bound
    // on the quotient (below 2^20 for every input) sets the stage count.
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        vaa_div_step #(
            .SHIFT (QUO_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (w_tag[g]),
            .o_ready (w_rdy[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .o_tag   (w_tag[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // Output register: quotient times 1024, sign restored from d.
    assign w_en_out     = !r_out_valid || m_axis_tready;
    assign w_rdy[QUO_W] = w_en_out;

    assign w_mag      = OUT_W'({w_quo[QUO_W], OUT_SH'(0)});
    assign n_out_data = w_tag[QUO_W].neg ? (OUT_W'(0) - w_mag) : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_tag[QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data};

endmodule

/* verif/tb_vector_angle_atan_approx.sv */
module tb_vector_angle_atan_approx;

    timeunit 1ns;
    timeprecision 1ps;

    // Angle arithmetic constants, kept apart from the RTL's copy.
    localparam longint unsigned SCALE_K  = 64'd683565275;
    localparam longint unsigned Q_GAIN   = 64'd1024;
    localparam longint unsigned D_GAIN   = 64'd287;
    localparam longint unsigned OUT_GAIN = 64'd1024;

    localparam int PIPE_LATENCY  = 24;       // accept to valid, from the RTL stage counts
    localparam int RANDOM_CNT    = 700;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AFTER    = 150;      // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 300;

    // Receiver ready patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_COIN   = 1;
    localparam int RDY_SPARSE = 2;
    localparam int RDY_MOSTLY = 3;

    typedef struct {
        logic signed [15:0] d;
        logic signed [15:0] q;
        logic        [30:0] angle;
    } t_angle_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] d_component, [31:16] q_component
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [30:0] phase_angle, [31] zero

    logic [31:0] vector_queue[$];     // items still to be offered
    t_angle_rec  angle_queue[$];      // predicted angles, oldest first

    int error_count   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int ready_seg     = 0;
    int ready_mode    = RDY_ALWAYS;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    vector_angle_atan_approx dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Rational atan: d*q*K / (1024 q^2 + 287 d^2), truncated, times 1024.
    // Sign is carried on |d| so truncation is symmetric about zero.
    function automatic logic [30:0] approx_angle(logic signed [15:0] d,
                                                 logic signed [15:0] q);
        longint unsigned dm;
        longint unsigned qm;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mag;
        int              di;
        logic            neg;
        if (q <= 0) begin
            return '0;
        end
        di  = d;
        neg = d[15];
        dm  = neg ? longint'(-di) : longint'(di);
        qm  = longint'(int'(q));
        num = dm * qm * SCALE_K;
        den = qm * qm * Q_GAIN + dm * dm * D_GAIN;
        mag = (num / den) * OUT_GAIN;
        if (neg) begin
            mag = 64'd0 - mag;
        end
        return mag[30:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_vector(input logic signed [15:0] d, input logic signed [15:0] q);
        vector_queue.push_back({q, d});
    endtask

    // Signed value of random magnitude: full-range patterns half the time,
    // otherwise a short word so small and mid-size ratios show up too.
    function automatic logic signed [15:0] rand_signed();
        int w;
        int v;
        if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom);
        end
        w = $urandom_range(1, 15);
        v = $urandom_range(0, (1 << w) - 1);
        return ($urandom_range(0, 1) == 0) ? 16'(v) : 16'(-v);
    endfunction

    function automatic logic signed [15:0] rand_pos_q();
        int w;
        w = $urandom_range(1, 15);
        return 16'($urandom_range(1, (1 << w) - 1));
    endfunction

    // Sender: bursts of random length separated by random gaps. A held
    // item keeps valid high until the handshake; valid is assigned at most once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                angle_queue.push_back('{d: s_axis_tdata[15:0], q: s_axis_tdata[31:16],
                    angle: approx_angle(s_axis_tdata[15:0], s_axis_tdata[31:16])});
                void'(vector_queue.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // item still on offer, hold
            end else if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (vector_queue.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= vector_queue[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: segments of always-ready, coin-flip, sparse and mostly-ready ready, plus
    // one long hold-off so the pipe fills and back-pressures the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (ready_seg == 0) begin
                ready_seg  <= $urandom_range(10, 60);
                ready_mode <= $urandom_range(RDY_ALWAYS, RDY_MOSTLY);
            end else begin
                ready_seg <= ready_seg - 1;
            end
            case (ready_mode)
                RDY_ALWAYS: m_axis_tready <= 1'b1;
                RDY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 0);
                RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (angle_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result phase_angle=%h",
                    m_axis_tdata[30:0]));
            end else begin
                if (m_axis_tdata[30:0] !== angle_queue[0].angle) begin
                    report_mismatch($sformatf("d=%0d q=%0d phase_angle got %h exp %h",
                        angle_queue[0].d, angle_queue[0].q, m_axis_tdata[30:0],
                        angle_queue[0].angle));
                end
                void'(angle_queue.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("vector_angle_atan_approx regression: fail");
            $finish;
        end
    end

    initial begin
        // Directed: corners, q <= 0 folds to zero, d == 0, sign symmetry.
        add_vector(16'sd0,      16'sd0);
        add_vector(16'sd32767,  16'sd32767);
        add_vector(-16'sd32768, 16'sd32767);
        add_vector(-16'sd32768, -16'sd32768);
        add_vector(16'sd32767,  -16'sd32768);
        add_vector(16'sd32767,  16'sd0);
        add_vector(-16'sd32768, 16'sd0);
        add_vector(16'sd100,    -16'sd1);
        add_vector(-16'sd100,   -16'sd1);
        add_vector(16'sd0,      16'sd1);
        add_vector(16'sd0,      16'sd32767);
        add_vector(16'sd1,      16'sd1);
        add_vector(-16'sd1,     16'sd1);
        add_vector(16'sd32767,  16'sd1);
        add_vector(-16'sd32767, 16'sd1);
        add_vector(-16'sd32768, 16'sd1);
        add_vector(16'sd1,      16'sd32767);
        add_vector(-16'sd1,     16'sd32767);
        add_vector(16'sd5000,   16'sd3000);
        add_vector(-16'sd5000,  16'sd3000);
        add_vector(16'sd3000,   16'sd5000);
        add_vector(-16'sd3000,  16'sd5000);
        add_vector(16'sd19124,  16'sd32767);
        add_vector(-16'sd19124, 16'sd32767);
        add_vector(16'sd12345,  16'sd0);
        for (int i = 0; i < RANDOM_CNT; i++) begin
            // Mostly q > 0 so the divider does real work; the rest is raw.
            if ($urandom_range(0, 9) < 8) begin
                add_vector(rand_signed(), rand_pos_q());
            end else begin
                vector_queue.push_back($urandom);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vector_queue.size() != 0 || s_axis_tvalid || angle_queue.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray result drain out before the verdict.
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);

        if (error_count == 0 && angle_queue.size() == 0) begin
            $display("vector_angle_atan_approx regression: pass");
        end else begin
            $display("vector_angle_atan_approx regression: fail");
        end
        $finish;
    end

endmodule
